>>> sv/utm_pkg.sv
// Shared types, constants and a helper function of the usage threshold monitor.
package utm_pkg;

    localparam int SLOTS    = 8;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DVD_W    = 55;
    localparam int DVS_W    = 48;
    localparam int CNT_W    = $clog2(DVD_W + 1);
    localparam logic [9:0] PCT_MAX = 10'd1023;

    typedef enum logic [1:0] {
        PH_NORMAL   = 2'd0,
        PH_EXCEEDED = 2'd1,
        PH_RECEDED  = 2'd2
    } phase_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_MEM = 1'b0,
        KIND_CPU = 1'b1
    } kind_t;

    typedef enum logic {
        DIR_EXCEEDED = 1'b0,
        DIR_RECEDED  = 1'b1
    } dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  slot;
        logic        mem_check;
        logic        cpu_check;
        logic [19:0] memory_mb;
        logic [47:0] app_ticks;
        logic [47:0] total_ticks;
        logic [39:0] time_ms;
        logic        end_of_round;
        logic [19:0] limit_mb;
        logic [9:0]  limit_percent;
        logic [15:0] hold_seconds;
    } sample_t;

    typedef struct packed {
        logic        event_kind;
        logic        direction;
        logic [2:0]  event_slot;
        logic [19:0] event_value;
        logic        last_event;
    } report_t;

    typedef struct packed {
        logic [15:0] hold_seconds;
        logic [9:0]  limit_percent;
        logic [19:0] limit_mb;
        logic [19:0] mem_latched;
        phase_t      cpu_phase;
        logic [47:0] prev_app_ticks;
        logic [39:0] phase_start_ms;
        logic [9:0]  latched_percent;
        logic        event_sent;
    } slot_entry_t;

    // x / 20 as (x / 4) * 52429 / 2^18, exact for every 18-bit quarter.
    function automatic logic [19:0] div20(input logic [19:0] x);
        logic [33:0] prod;
        begin
            prod = 34'(x[19:2]) * 34'(52429);
            return 20'(prod[33:18]);
        end
    endfunction

endpackage

>>> sv/usage_threshold_monitor_unit.sv
// Top level of the usage threshold monitor.
// Per-slot memory and CPU usage watchdog. A load beat is written when it is accepted
// and the block is ready again in the next cycle. A sample beat runs the divider only
// when a CPU percent is computed: the percent comes from a restoring divider that
// retires one quotient bit a cycle over a 55-bit dividend. Slot state sits in one
// synchronous memory, read when the beat is accepted and written back at the end.
// Up to two report beats per sample (memory event first) wait in an output buffer; a
// new sample is accepted while they wait, and its results are written once it empties.
module usage_threshold_monitor_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  utm_pkg::sample_t sample_beat,
    output logic             report_valid,
    input  logic             report_stall,
    output utm_pkg::report_t report_beat
);

    utm_pkg::state_t state_reg, state_next;

    utm_pkg::slot_entry_t mem_array [utm_pkg::SLOTS];
    utm_pkg::slot_entry_t rd_data_reg;
    logic [utm_pkg::SLOTS-1:0] valid_reg;
    logic rd_valid_reg;

    utm_pkg::sample_t req_reg;
    utm_pkg::slot_entry_t ent_reg, ent_next;
    logic [47:0] prev_total_reg;

    logic [utm_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [utm_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [utm_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [utm_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [utm_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    logic [39:0] elapsed_reg, elapsed_next;
    logic [25:0] hold_ms_reg, hold_ms_next;
    logic [19:0] mem_thr_reg, mem_thr_next;
    logic [9:0]  pct_thr_reg, pct_thr_next;
    logic        pt_nz_reg, pt_nz_next;
    logic        pa_nz_reg, pa_nz_next;
    logic        ratio_ok_reg, ratio_ok_next;

    utm_pkg::report_t res_reg [2];
    logic [1:0] res_cnt_reg;

    logic accept, take;
    logic do_write, do_load;
    utm_pkg::slot_entry_t wr_entry;
    logic [utm_pkg::SLOT_W-1:0] wr_addr;
    logic [utm_pkg::SLOT_W-1:0] rd_addr;

    logic evt_mem, evt_cpu;
    utm_pkg::report_t rep_mem, rep_cpu;

    logic [48:0] rem_sh;
    logic        rem_ge;
    logic [9:0]  pct;
    utm_pkg::slot_entry_t cur;

    assign accept       = sample_valid && !sample_stall;
    assign take         = report_valid && !report_stall;
    assign sample_stall = (state_reg != utm_pkg::ST_IDLE);
    assign report_valid = (res_cnt_reg != 2'd0);
    assign report_beat  = res_reg[0];
    assign do_load      = accept && (sample_beat.opcode == utm_pkg::OP_LOAD);
    assign rd_addr      = sample_beat.slot[utm_pkg::SLOT_W-1:0];

    // Restoring divider step.
    assign rem_sh = {rem_reg, dvd_reg[utm_pkg::DVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    always_comb
    begin
        cur = rd_valid_reg ? rd_data_reg : '0;
        pct = '0;
        if (ratio_ok_reg)
        begin
            pct = (quo_reg > utm_pkg::DVD_W'(utm_pkg::PCT_MAX)) ? utm_pkg::PCT_MAX
                                                               : quo_reg[9:0];
        end
    end

    always_comb
    begin
        utm_pkg::phase_t ph;
        logic [47:0] usage;
        logic hold_met;
        state_next    = state_reg;
        ent_next      = ent_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        elapsed_next  = elapsed_reg;
        hold_ms_next  = hold_ms_reg;
        mem_thr_next  = mem_thr_reg;
        pct_thr_next  = pct_thr_reg;
        pt_nz_next    = pt_nz_reg;
        pa_nz_next    = pa_nz_reg;
        ratio_ok_next = ratio_ok_reg;
        evt_mem       = 1'b0;
        evt_cpu       = 1'b0;
        rep_mem       = '0;
        rep_cpu       = '0;
        do_write      = 1'b0;
        wr_entry      = '0;
        wr_addr       = rd_addr;
        ph            = utm_pkg::PH_NORMAL;
        usage         = '0;
        hold_met      = 1'b0;

        case (state_reg)
            utm_pkg::ST_IDLE:
            begin
                if (do_load)
                begin
                    do_write               = 1'b1;
                    wr_entry.limit_mb      = sample_beat.limit_mb;
                    wr_entry.limit_percent = sample_beat.limit_percent;
                    wr_entry.hold_seconds  = sample_beat.hold_seconds;
                    wr_entry.cpu_phase     = utm_pkg::PH_NORMAL;
                end
                else if (accept)
                begin
                    state_next = utm_pkg::ST_READ;
                end
            end
            utm_pkg::ST_READ:
            begin
                ent_next      = cur;
                pt_nz_next    = (prev_total_reg != '0);
                pa_nz_next    = (cur.prev_app_ticks != '0);
                ratio_ok_next = (req_reg.app_ticks >= cur.prev_app_ticks) &&
                                (req_reg.total_ticks > prev_total_reg);
                dvd_next      = utm_pkg::DVD_W'(req_reg.app_ticks - cur.prev_app_ticks) *
                                utm_pkg::DVD_W'(100);
                dvs_next      = req_reg.total_ticks - prev_total_reg;
                rem_next      = '0;
                quo_next      = '0;
                cnt_next      = '0;
                elapsed_next  = (req_reg.time_ms >= cur.phase_start_ms) ?
                                req_reg.time_ms - cur.phase_start_ms : '0;
                hold_ms_next  = 26'(cur.hold_seconds) * 26'(1000);
                mem_thr_next  = cur.mem_latched - utm_pkg::div20(cur.mem_latched);
                pct_thr_next  = cur.latched_percent -
                                10'(utm_pkg::div20(20'(cur.latched_percent)));
                if (req_reg.cpu_check && ratio_ok_next && pt_nz_next && pa_nz_next)
                    state_next = utm_pkg::ST_DIV;
                else
                    state_next = utm_pkg::ST_EVAL;
            end
            utm_pkg::ST_DIV:
            begin
                rem_next = rem_ge ? utm_pkg::DVS_W'(rem_sh - {1'b0, dvs_reg})
                                  : rem_sh[utm_pkg::DVS_W-1:0];
                quo_next = {quo_reg[utm_pkg::DVD_W-2:0], rem_ge};
                dvd_next = {dvd_reg[utm_pkg::DVD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == utm_pkg::CNT_W'(utm_pkg::DVD_W - 1))
                    state_next = utm_pkg::ST_EVAL;
            end
            utm_pkg::ST_EVAL:
            begin
                // Results go out only into an empty buffer.
                if (res_cnt_reg == 2'd0)
                begin
                    wr_entry = ent_reg;
                    wr_addr  = req_reg.slot[utm_pkg::SLOT_W-1:0];
                    do_write = 1'b1;
                    hold_met = (elapsed_reg >= 40'(hold_ms_reg));

                    if (req_reg.mem_check)
                    begin
                        if (req_reg.memory_mb >= ent_reg.limit_mb)
                        begin
                            if (ent_reg.mem_latched == '0)
                            begin
                                wr_entry.mem_latched = req_reg.memory_mb;
                                evt_mem = 1'b1;
                                rep_mem.direction = utm_pkg::DIR_EXCEEDED;
                            end
                        end
                        else if (ent_reg.mem_latched != '0 && req_reg.memory_mb < mem_thr_reg)
                        begin
                            wr_entry.mem_latched = '0;
                            evt_mem = 1'b1;
                            rep_mem.direction = utm_pkg::DIR_RECEDED;
                        end
                        rep_mem.event_kind  = utm_pkg::KIND_MEM;
                        rep_mem.event_slot  = req_reg.slot;
                        rep_mem.event_value = req_reg.memory_mb;
                    end

                    if (req_reg.cpu_check)
                    begin
                        usage = pt_nz_reg ? req_reg.app_ticks : '0;
                        if (pt_nz_reg && pa_nz_reg)
                        begin
                            case (ent_reg.cpu_phase)
                                utm_pkg::PH_EXCEEDED: ph = utm_pkg::PH_EXCEEDED;
                                utm_pkg::PH_RECEDED:  ph = utm_pkg::PH_RECEDED;
                                default:              ph = utm_pkg::PH_NORMAL;
                            endcase
                            rep_cpu.event_kind  = utm_pkg::KIND_CPU;
                            rep_cpu.event_slot  = req_reg.slot;
                            rep_cpu.event_value = 20'(pct);
                            if (pct >= ent_reg.limit_percent)
                            begin
                                if (ph == utm_pkg::PH_NORMAL)
                                begin
                                    ph = utm_pkg::PH_EXCEEDED;
                                    wr_entry.phase_start_ms  = req_reg.time_ms;
                                    wr_entry.latched_percent = pct;
                                    wr_entry.event_sent      = 1'b0;
                                end
                                else if (ph == utm_pkg::PH_EXCEEDED)
                                begin
                                    if (!ent_reg.event_sent && hold_met)
                                    begin
                                        evt_cpu = 1'b1;
                                        rep_cpu.direction   = utm_pkg::DIR_EXCEEDED;
                                        wr_entry.event_sent = 1'b1;
                                    end
                                end
                                else
                                begin
                                    ph = utm_pkg::PH_EXCEEDED;
                                end
                            end
                            else if (ph == utm_pkg::PH_EXCEEDED)
                            begin
                                if (!ent_reg.event_sent)
                                begin
                                    ph = utm_pkg::PH_NORMAL;
                                end
                                else if (pct < pct_thr_reg)
                                begin
                                    ph = utm_pkg::PH_RECEDED;
                                    wr_entry.phase_start_ms = req_reg.time_ms;
                                end
                            end
                            else if (ph == utm_pkg::PH_RECEDED)
                            begin
                                if (pct < pct_thr_reg)
                                begin
                                    if (hold_met)
                                    begin
                                        evt_cpu = 1'b1;
                                        rep_cpu.direction = utm_pkg::DIR_RECEDED;
                                        ph = utm_pkg::PH_NORMAL;
                                    end
                                end
                                else
                                begin
                                    ph = utm_pkg::PH_EXCEEDED;
                                end
                            end
                            wr_entry.cpu_phase = ph;
                        end
                        wr_entry.prev_app_ticks = usage;
                    end
                    state_next = utm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = utm_pkg::ST_IDLE;
            end
        endcase
    end

    // Slot state memory.
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem_array[wr_addr] <= wr_entry;
        rd_data_reg <= mem_array[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= sample_beat;
        ent_reg      <= ent_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        elapsed_reg  <= elapsed_next;
        hold_ms_reg  <= hold_ms_next;
        mem_thr_reg  <= mem_thr_next;
        pct_thr_reg  <= pct_thr_next;
        pt_nz_reg    <= pt_nz_next;
        pa_nz_reg    <= pa_nz_next;
        ratio_ok_reg <= ratio_ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= utm_pkg::ST_IDLE;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            prev_total_reg <= '0;
            cnt_reg        <= '0;
            res_cnt_reg    <= '0;
            res_reg[0]     <= '0;
            res_reg[1]     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= valid_reg[rd_addr];
            if (do_write)
                valid_reg[wr_addr] <= 1'b1;

            if (do_load)
                prev_total_reg <= '0;
            else if (state_reg == utm_pkg::ST_EVAL && do_write &&
                     req_reg.cpu_check && req_reg.end_of_round)
                prev_total_reg <= req_reg.total_ticks;

            if (state_reg == utm_pkg::ST_EVAL && do_write)
            begin
                if (evt_mem && evt_cpu)
                begin
                    res_reg[0] <= rep_mem;
                    res_reg[1] <= '{event_kind: rep_cpu.event_kind,
                                    direction: rep_cpu.direction,
                                    event_slot: rep_cpu.event_slot,
                                    event_value: rep_cpu.event_value,
                                    last_event: 1'b1};
                    res_cnt_reg <= 2'd2;
                end
                else if (evt_mem)
                begin
                    res_reg[0] <= '{event_kind: rep_mem.event_kind,
                                    direction: rep_mem.direction,
                                    event_slot: rep_mem.event_slot,
                                    event_value: rep_mem.event_value,
                                    last_event: 1'b1};
                    res_cnt_reg <= 2'd1;
                end
                else if (evt_cpu)
                begin
                    res_reg[0] <= '{event_kind: rep_cpu.event_kind,
                                    direction: rep_cpu.direction,
                                    event_slot: rep_cpu.event_slot,
                                    event_value: rep_cpu.event_value,
                                    last_event: 1'b1};
                    res_cnt_reg <= 2'd1;
                end
            end
            else if (take)
            begin
                res_reg[0]  <= res_reg[1];
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

endmodule

>>> sv/usage_threshold_monitor_unit_checker.sv
// Port-level checker for the usage threshold monitor and its bind.
module usage_threshold_monitor_unit_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_stall,
    input utm_pkg::sample_t sample_beat,
    input logic             report_valid,
    input logic             report_stall,
    input utm_pkg::report_t report_beat
);

    // An accepted sample beat sets sample_stall, so the block takes no new beat while it works on the sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample_beat.opcode == utm_pkg::OP_SAMPLE
        |=> sample_stall)
        else $error("sample beat did not hold off the next beat");

    // A load creates no report.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall && sample_beat.opcode == utm_pkg::OP_LOAD &&
        !report_valid |=> !report_valid)
        else $error("load beat produced a report");

    // The second report of a sample follows directly after the first.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_stall && !report_beat.last_event |=> report_valid)
        else $error("second report of a sample went missing");

    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> report_valid)
        else $error("report valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report_stall |=> $stable(report_beat))
        else $error("stalled report beat changed");

endmodule

bind usage_threshold_monitor_unit usage_threshold_monitor_unit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_beat  (sample_beat),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report_beat  (report_beat)
);

>>> tb/usage_threshold_monitor_unit_tb.sv
// Self-checking testbench for the usage threshold monitor: predicts report beats per sample.
module usage_threshold_monitor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    utm_pkg::sample_t  sample_beat = '0;
    logic              report_valid;
    logic              report_stall = 1'b0;
    utm_pkg::report_t  report_beat;

    usage_threshold_monitor_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample_beat(sample_beat),
        .report_valid(report_valid), .report_stall(report_stall), .report_beat(report_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state for each slot, and the previous total shared by all slots.
    logic [19:0]     lim_mb [utm_pkg::SLOTS];
    logic [9:0]      lim_pct [utm_pkg::SLOTS];
    logic [15:0]     hold_s [utm_pkg::SLOTS];
    logic [19:0]     mem_latch [utm_pkg::SLOTS];
    utm_pkg::phase_t phase [utm_pkg::SLOTS];
    logic [47:0]     prev_app [utm_pkg::SLOTS];
    logic [39:0]     phase_t0 [utm_pkg::SLOTS];
    logic [9:0]      pct_latch [utm_pkg::SLOTS];
    logic            cpu_reported [utm_pkg::SLOTS];
    logic [47:0]     prev_total;

    utm_pkg::report_t pending_reports[$];
    int      mismatches = 0;
    int      reports_seen = 0;
    int      samples_sent = 0;
    int      idle_cycles = 0;
    int      cpu_events = 0;
    int      mem_events = 0;

    function automatic bit hold_elapsed(int s, logic [39:0] now);
        logic [63:0] elapsed;
        elapsed = (now >= phase_t0[s]) ? 64'(now - phase_t0[s]) : 64'd0;
        return elapsed >= 64'(hold_s[s]) * 64'd1000;
    endfunction

    function automatic void push_report(utm_pkg::kind_t k, utm_pkg::dir_t d, int s,
                                        logic [19:0] v);
        utm_pkg::report_t r;
        r.event_kind = k;
        r.direction = d;
        r.event_slot = 3'(s);
        r.event_value = v;
        r.last_event = 1'b0;
        pending_reports = {pending_reports, r};
        if (k == utm_pkg::KIND_CPU)
            cpu_events++;
        else
            mem_events++;
    endfunction

    function automatic void predict_usage(utm_pkg::sample_t b);
        int              s;
        int              n_prior;
        logic [47:0]     usage;
        logic [9:0]      pct;
        logic [9:0]      thr;
        logic [63:0]     q;
        utm_pkg::phase_t ph;
        s = int'(b.slot);
        n_prior = pending_reports.size();
        if (b.opcode == utm_pkg::OP_LOAD) begin
            lim_mb[s] = b.limit_mb;
            lim_pct[s] = b.limit_percent;
            hold_s[s] = b.hold_seconds;
            mem_latch[s] = '0;
            phase[s] = utm_pkg::PH_NORMAL;
            prev_app[s] = '0;
            phase_t0[s] = '0;
            pct_latch[s] = '0;
            cpu_reported[s] = 1'b0;
            prev_total = '0;
            return;
        end
        if (b.mem_check) begin
            if (b.memory_mb >= lim_mb[s]) begin
                if (mem_latch[s] == 0) begin
                    mem_latch[s] = b.memory_mb;
                    push_report(utm_pkg::KIND_MEM, utm_pkg::DIR_EXCEEDED, s, b.memory_mb);
                end
            end else if (mem_latch[s] != 0 &&
                         b.memory_mb < mem_latch[s] - mem_latch[s] / 20) begin
                mem_latch[s] = '0;
                push_report(utm_pkg::KIND_MEM, utm_pkg::DIR_RECEDED, s, b.memory_mb);
            end
        end
        if (b.cpu_check) begin
            usage = '0;
            if (prev_total != 0) begin
                usage = b.app_ticks;
                if (prev_app[s] != 0) begin
                    pct = '0;
                    thr = pct_latch[s] - pct_latch[s] / 20;
                    ph = phase[s];
                    if (usage >= prev_app[s] && b.total_ticks > prev_total) begin
                        q = (64'd100 * 64'(usage - prev_app[s])) / 64'(b.total_ticks - prev_total);
                        pct = (q > 64'd1023) ? utm_pkg::PCT_MAX : q[9:0];
                    end
                    if (ph != utm_pkg::PH_EXCEEDED && ph != utm_pkg::PH_RECEDED)
                        ph = utm_pkg::PH_NORMAL;
                    if (pct >= lim_pct[s]) begin
                        if (ph == utm_pkg::PH_NORMAL) begin
                            ph = utm_pkg::PH_EXCEEDED;
                            phase_t0[s] = b.time_ms;
                            pct_latch[s] = pct;
                            cpu_reported[s] = 1'b0;
                        end else if (ph == utm_pkg::PH_EXCEEDED) begin
                            if (!cpu_reported[s] && hold_elapsed(s, b.time_ms)) begin
                                push_report(utm_pkg::KIND_CPU, utm_pkg::DIR_EXCEEDED, s,
                                            20'(pct));
                                cpu_reported[s] = 1'b1;
                            end
                        end else begin
                            ph = utm_pkg::PH_EXCEEDED;
                        end
                    end else if (ph == utm_pkg::PH_EXCEEDED) begin
                        if (!cpu_reported[s])
                            ph = utm_pkg::PH_NORMAL;
                        else if (pct < thr) begin
                            ph = utm_pkg::PH_RECEDED;
                            phase_t0[s] = b.time_ms;
                        end
                    end else if (ph == utm_pkg::PH_RECEDED) begin
                        if (pct < thr) begin
                            if (hold_elapsed(s, b.time_ms)) begin
                                push_report(utm_pkg::KIND_CPU, utm_pkg::DIR_RECEDED, s,
                                            20'(pct));
                                ph = utm_pkg::PH_NORMAL;
                            end
                        end else begin
                            ph = utm_pkg::PH_EXCEEDED;
                        end
                    end
                    phase[s] = ph;
                end
            end
            prev_app[s] = usage;
        end
        if (b.cpu_check && b.end_of_round)
            prev_total = b.total_ticks;
        if (pending_reports.size() > n_prior)
            pending_reports[$].last_event = 1'b1;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 150);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    function automatic utm_pkg::sample_t random_sample();
        logic [223:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return utm_pkg::sample_t'(rnd[$bits(utm_pkg::sample_t)-1:0]);
    endfunction

    // Stall pattern on the report side; some stretches run with no stall at all.
    bit stall_free = 1'b0;
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            report_stall <= 1'b1;
        end else begin
            report_stall <= 1'b0;
            if (!stall_free && $urandom_range(0, 3) == 0)
                stall_left <= random_gap();
        end
    end

    // Checks report beats against the predicted queue.
    always @(posedge clk)
    begin
        if (rst_n && report_valid && !report_stall) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report beat %p", report_beat);
            end else begin
                utm_pkg::report_t want;
                want = pending_reports.pop_front();
                if (report_beat !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch: expected %p, got %p", want, report_beat);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat in either direction.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (report_valid && !report_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("usage_threshold_monitor_unit: mismatch");
            $finish;
        end
    end

    // Valid stays high into the next beat when there is no gap, so it is
    // dropped only at the start of an idle stretch.
    task automatic send_sample(utm_pkg::sample_t b);
        int gap;
        gap = stall_free ? 0 : random_gap();
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_beat <= b;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        predict_usage(b);
        samples_sent++;
    endtask

    task automatic drain_reports();
        sample_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic utm_pkg::sample_t usage_beat(int s, bit mc, bit cc, logic [19:0] mem,
                                                    logic [47:0] app, logic [47:0] total,
                                                    logic [39:0] now, bit eor);
        utm_pkg::sample_t b;
        b = '0;
        b.opcode = utm_pkg::OP_SAMPLE;
        b.slot = 3'(s);
        b.mem_check = mc;
        b.cpu_check = cc;
        b.memory_mb = mem;
        b.app_ticks = app;
        b.total_ticks = total;
        b.time_ms = now;
        b.end_of_round = eor;
        return b;
    endfunction

    function automatic utm_pkg::sample_t load_beat(int s, logic [19:0] mb, logic [9:0] pct,
                                                   logic [15:0] hold);
        utm_pkg::sample_t b;
        b = random_sample();
        b.opcode = utm_pkg::OP_LOAD;
        b.slot = 3'(s);
        b.limit_mb = mb;
        b.limit_percent = pct;
        b.hold_seconds = hold;
        return b;
    endfunction

    task automatic test_memory_edges();
        send_sample(load_beat(0, 20'd1000, 10'd50, 16'd0));
        send_sample(usage_beat(0, 1, 0, 20'd999, '0, '0, '0, 0));
        send_sample(usage_beat(0, 1, 0, 20'd1000, '0, '0, '0, 0));
        send_sample(usage_beat(0, 1, 0, 20'd951, '0, '0, '0, 0));
        send_sample(usage_beat(0, 1, 0, 20'd949, '0, '0, '0, 0));
        send_sample(load_beat(1, 20'd0, 10'd1023, 16'hFFFF));
        send_sample(usage_beat(1, 1, 0, 20'd0, '0, '0, '0, 0));
        send_sample(usage_beat(1, 1, 0, 20'hFFFFF, '0, '0, '0, 0));
        send_sample(load_beat(2, 20'hFFFFF, 10'd0, 16'd0));
        send_sample(usage_beat(2, 1, 0, 20'hFFFFF, '0, '0, 40'hFF_FFFF_FFFF, 1));
    endtask

    task automatic test_cpu_machine();
        send_sample(load_beat(3, 20'hFFFFF, 10'd40, 16'd1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd10, 48'd100, 40'd0, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd10, 48'd200, 40'd0, 1));
        send_sample(usage_beat(3, 1, 1, 20'hFFFFF, 48'd60, 48'd300, 40'd100, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd110, 48'd400, 40'd1100, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd111, 48'd500, 40'd1200, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd112, 48'd600, 40'd2300, 1));
        // Saturated percent, a wrapped app counter and a stalled total.
        send_sample(usage_beat(3, 0, 1, '0, 48'hFFFF_FFFF_FFFF, 48'd601, 40'd2400, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd5, 48'd700, 40'd0, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd9, 48'd700, 40'd9000, 1));
        send_sample(usage_beat(3, 0, 1, '0, 48'd9, 48'hFFFF_FFFF_FFFF, 40'd9999, 1));
        drain_reports();
    endtask

    // Rounds of well-formed samples across all slots, with random load beats and random samples mixed in.
    task automatic test_random_rounds(int count);
        logic [47:0]      app [utm_pkg::SLOTS];
        logic [47:0]      total;
        logic [39:0]      now;
        int               s;
        int               done;
        bit               drained;
        utm_pkg::sample_t b;
        done = 0;
        drained = 1'b0;
        total = 48'($urandom_range(1, 1000));
        now = 40'($urandom);
        for (int i = 0; i < utm_pkg::SLOTS; i++)
            app[i] = 48'($urandom_range(1, 100));
        while (done < count) begin
            if (!drained && done >= count / 2) begin
                drain_reports();
                drained = 1'b1;
            end
            stall_free = (done >= count / 3) && (done < count / 3 + 100);
            if ($urandom_range(0, 39) == 0) begin
                send_sample(load_beat($urandom_range(0, utm_pkg::SLOTS - 1),
                                      20'($urandom_range(100, 400)),
                                      10'($urandom_range(0, 120)),
                                      16'($urandom_range(0, 3))));
                done++;
                continue;
            end
            if ($urandom_range(0, 19) == 0) begin
                b = random_sample();
                b.opcode = utm_pkg::OP_SAMPLE;
                send_sample(b);
                done++;
                continue;
            end
            total = total + 48'($urandom_range(50, 200));
            now = now + 40'($urandom_range(100, 1500));
            for (s = 0; s < utm_pkg::SLOTS && done < count; s++) begin
                app[s] = app[s] + 48'($urandom_range(0, 150));
                send_sample(usage_beat(s, $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0,
                                       20'($urandom_range(0, 500)), app[s], total, now,
                                       s == utm_pkg::SLOTS - 1));
                done++;
            end
        end
        stall_free = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < utm_pkg::SLOTS; i++) begin
            lim_mb[i] = '0; lim_pct[i] = '0; hold_s[i] = '0; mem_latch[i] = '0;
            phase[i] = utm_pkg::PH_NORMAL; prev_app[i] = '0; phase_t0[i] = '0;
            pct_latch[i] = '0; cpu_reported[i] = 1'b0;
        end
        prev_total = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_edges();
        test_cpu_machine();
        test_random_rounds(1130);
        drain_reports();
        $display("sent %0d samples, checked %0d report beats", samples_sent, reports_seen);
        $display("memory events %0d, cpu events %0d", mem_events, cpu_events);
        if (mismatches == 0)
            $display("usage_threshold_monitor_unit: match");
        else
            $display("usage_threshold_monitor_unit: mismatch");
        $finish;
    end
endmodule

>>> sim.f
sv/utm_pkg.sv
sv/usage_threshold_monitor_unit.sv
sv/usage_threshold_monitor_unit_checker.sv
tb/usage_threshold_monitor_unit_tb.sv
